// File: src/prgp_pkg.sv
// Shared types and constants for the pixel resolve, gamma and pack block.
package prgp_pkg;

  localparam int MAX_DIM_DEF         = 4096;
  localparam int COLOR_FRAC_BITS_DEF = 16;

  localparam int SPP_W      = 11;
  localparam int DIM_CFG_W  = 13;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 13;
  localparam int POS_W      = 16;
  localparam int SUM_W      = 32;
  localparam int ADDR_W     = 24;
  localparam int CHAN_W     = 8;
  localparam int WORD_W     = 32;
  localparam int NUM_CHAN   = 3;

  localparam int CH_RED   = 0;
  localparam int CH_GREEN = 1;
  localparam int CH_BLUE  = 2;

  localparam int QUEUE_DEPTH     = 4;
  localparam int DIV_BITS_PER_ST = 4;
  localparam int ROOT_BITS_PER_ST = 2;

  localparam logic [SPP_W-1:0]     SPP_RESET    = 11'd1;
  localparam logic [DIM_CFG_W-1:0] WIDTH_RESET  = 13'd640;
  localparam logic [DIM_CFG_W-1:0] HEIGHT_RESET = 13'd480;
  localparam logic [CHAN_W-1:0]    ALPHA_OPAQUE = 8'hFF;
  localparam logic [CHAN_W-1:0]    CHAN_MAX     = 8'hFF;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SPP    = 2'd0,
    CFG_WIDTH  = 2'd1,
    CFG_HEIGHT = 2'd2
  } cfg_idx_t;

  // Item handed from the front to the back through the queue.
  typedef struct packed {
    logic                          in_frame;
    logic [POS_W-1:0]              row;
    logic [POS_W-1:0]              col;
    logic [NUM_CHAN-1:0][SUM_W-1:0] sum;
  } item_t;

endpackage

// File: src/pixel_resolve_gamma_pack.sv
// Top level of the pixel resolve block: configuration registers, front, queue and back.
//
// Each item carries a pixel position and three colour sums in unsigned fixed
// point. The block divides every sum by the sample count, applies gamma 2 as
// an integer square root saturated to 255, flips the row against the frame
// height, checks the bounds and returns the in-frame flag, the linear address
// and an opaque ARGB8888 word. It takes one item per clock cycle for as long
// as results are taken. An accepted item passes the input stage, the queue,
// the division pipeline (four quotient bits per stage), the square root
// pipeline (two result bits per stage) and then the output register. A
// four-entry queue between the input stage and the pipeline absorbs output
// stalls. Configuration is to be written only while no item is in flight;
// the block itself does not enforce this.
module pixel_resolve_gamma_pack import prgp_pkg::*; #(
  parameter int MAX_DIM         = MAX_DIM_DEF,
  parameter int COLOR_FRAC_BITS = COLOR_FRAC_BITS_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    cfg_we,
  input  logic [CFG_IDX_W-1:0]    cfg_index,
  input  logic [CFG_DATA_W-1:0]   cfg_data,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic signed [POS_W-1:0] in_pos_x,
  input  logic signed [POS_W-1:0] in_pos_y,
  input  logic [SUM_W-1:0]        in_red_sum,
  input  logic [SUM_W-1:0]        in_green_sum,
  input  logic [SUM_W-1:0]        in_blue_sum,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic                    out_in_frame,
  output logic [ADDR_W-1:0]       out_pixel_address,
  output logic [WORD_W-1:0]       out_pixel_word
);

  localparam int DIM_W  = $clog2(MAX_DIM + 1);
  localparam int CLMP_W = (DIM_W > DIM_CFG_W) ? DIM_W : DIM_CFG_W;
  localparam int ITEM_W = $bits(item_t);

  logic [SPP_W-1:0]     spp_r;
  logic [DIM_CFG_W-1:0] width_r;
  logic [DIM_CFG_W-1:0] height_r;

  logic [SPP_W-1:0] spp_eff;
  logic [DIM_W-1:0] w_eff;
  logic [DIM_W-1:0] h_eff;

  logic              q_push, q_pop, q_full, q_empty;
  item_t             q_item_in, q_item_out;
  logic [ITEM_W-1:0] q_rdata;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      spp_r    <= SPP_RESET;
      width_r  <= WIDTH_RESET;
      height_r <= HEIGHT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_SPP:    spp_r    <= cfg_data[SPP_W-1:0];
        CFG_WIDTH:  width_r  <= cfg_data[DIM_CFG_W-1:0];
        CFG_HEIGHT: height_r <= cfg_data[DIM_CFG_W-1:0];
        default: ;
      endcase
    end
  end

  // A sample count of zero divides by one; oversized frames clamp to MAX_DIM.
  always_comb begin
    spp_eff = (spp_r == '0) ? SPP_W'(1) : spp_r;
    w_eff   = (CLMP_W'(width_r) > CLMP_W'(MAX_DIM)) ? DIM_W'(MAX_DIM) : DIM_W'(width_r);
    h_eff   = (CLMP_W'(height_r) > CLMP_W'(MAX_DIM)) ? DIM_W'(MAX_DIM) : DIM_W'(height_r);
  end

  prgp_front #(
    .MAX_DIM (MAX_DIM)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_pos_x     (in_pos_x),
    .in_pos_y     (in_pos_y),
    .in_red_sum   (in_red_sum),
    .in_green_sum (in_green_sum),
    .in_blue_sum  (in_blue_sum),
    .frame_w      (w_eff),
    .frame_h      (h_eff),
    .q_full       (q_full),
    .q_push       (q_push),
    .q_item       (q_item_in)
  );

  prgp_queue #(
    .WIDTH (ITEM_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_item_in),
    .full  (q_full),
    .pop   (q_pop),
    .rdata (q_rdata),
    .empty (q_empty)
  );

  assign q_item_out = item_t'(q_rdata);

  prgp_back #(
    .MAX_DIM         (MAX_DIM),
    .COLOR_FRAC_BITS (COLOR_FRAC_BITS)
  ) u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .q_empty           (q_empty),
    .q_pop             (q_pop),
    .q_data            (q_item_out),
    .spp               (spp_eff),
    .frame_w           (w_eff),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_in_frame      (out_in_frame),
    .out_pixel_address (out_pixel_address),
    .out_pixel_word    (out_pixel_word)
  );

endmodule

// File: src/prgp_queue.sv
// Small register queue that decouples the front from the back.
module prgp_queue import prgp_pkg::*; #(
  parameter int WIDTH = 8,
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  assign full  = (cnt_r == FULL_CNT);
  assign empty = (cnt_r == '0);
  assign rdata = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

endmodule

// File: src/prgp_front.sv
// Input stage: takes items, flips the row and decides whether the pixel is in frame.
module prgp_front import prgp_pkg::*; #(
  parameter int MAX_DIM = MAX_DIM_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic signed [POS_W-1:0]           in_pos_x,
  input  logic signed [POS_W-1:0]           in_pos_y,
  input  logic [SUM_W-1:0]                  in_red_sum,
  input  logic [SUM_W-1:0]                  in_green_sum,
  input  logic [SUM_W-1:0]                  in_blue_sum,
  input  logic [$clog2(MAX_DIM+1)-1:0]      frame_w,
  input  logic [$clog2(MAX_DIM+1)-1:0]      frame_h,
  input  logic                              q_full,
  output logic                              q_push,
  output item_t                             q_item
);

  localparam int DIM_W = $clog2(MAX_DIM + 1);
  localparam int CMP_W = ((DIM_W > POS_W) ? DIM_W : POS_W) + 2;
  localparam logic signed [CMP_W-1:0] ONE_S = 1;

  logic                     valid_r, valid_nxt;
  item_t                    item_r, item_nxt;
  logic                     in_acc;
  logic signed [CMP_W-1:0]  h_s, w_s, x_s, y_s, fy_s;

  assign in_stall = valid_r & q_full;
  assign in_acc   = in_valid & ~in_stall;
  assign q_push   = valid_r & ~q_full;
  assign q_item   = item_r;

  // The row is flipped in a signed width wide enough that it never wraps.
  always_comb begin
    h_s  = signed'(CMP_W'(frame_h));
    w_s  = signed'(CMP_W'(frame_w));
    x_s  = CMP_W'(in_pos_x);
    y_s  = CMP_W'(in_pos_y);
    fy_s = h_s - y_s - ONE_S;

    item_nxt.in_frame = ~fy_s[CMP_W-1] && (fy_s < h_s) && ~x_s[CMP_W-1] && (x_s < w_s);
    item_nxt.row    = fy_s[POS_W-1:0];
    item_nxt.col    = in_pos_x;
    item_nxt.sum[CH_RED]   = in_red_sum;
    item_nxt.sum[CH_GREEN] = in_green_sum;
    item_nxt.sum[CH_BLUE]  = in_blue_sum;

    valid_nxt = in_acc | (valid_r & q_full);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      item_r <= item_nxt;
    end
  end

endmodule

// File: src/prgp_back.sv
// Execution pipeline: address, per-channel division, square root and packing.
module prgp_back import prgp_pkg::*; #(
  parameter int MAX_DIM         = MAX_DIM_DEF,
  parameter int COLOR_FRAC_BITS = COLOR_FRAC_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          q_empty,
  output logic                          q_pop,
  input  item_t                         q_data,
  input  logic [SPP_W-1:0]              spp,
  input  logic [$clog2(MAX_DIM+1)-1:0]  frame_w,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          out_in_frame,
  output logic [ADDR_W-1:0]             out_pixel_address,
  output logic [WORD_W-1:0]             out_pixel_word
);

  localparam int DIM_W       = $clog2(MAX_DIM + 1);
  localparam int PROD_W      = 2 * DIM_W + 1;
  localparam int DIV_STAGES  = SUM_W / DIV_BITS_PER_ST;
  localparam int RAD_W       = 2 * CHAN_W;
  localparam int REM_W       = CHAN_W + 3;
  localparam int ROOT_STAGES = CHAN_W / ROOT_BITS_PER_ST;
  localparam int SHR = (COLOR_FRAC_BITS >= RAD_W) ? COLOR_FRAC_BITS - RAD_W : 0;
  localparam int SHL = (COLOR_FRAC_BITS <  RAD_W) ? RAD_W - COLOR_FRAC_BITS : 0;

  typedef struct packed {
    logic [SPP_W-1:0] rem;
    logic [SUM_W-1:0] num;
  } div_lane_t;

  typedef struct packed {
    logic             sat;
    logic [RAD_W-1:0] rad;
    logic [CHAN_W-1:0] root;
    logic [REM_W-1:0] rem;
  } root_lane_t;

  typedef struct packed {
    logic              in_frame;
    logic [ADDR_W-1:0] addr;
  } meta_t;

  // Restoring division; the quotient shifts into the dividend register.
  function automatic div_lane_t div_steps(div_lane_t a, logic [SPP_W-1:0] d);
    div_lane_t      s;
    logic [SPP_W:0] t;
    s = a;
    for (int i = 0; i < DIV_BITS_PER_ST; i++) begin
      t = {s.rem, s.num[SUM_W-1]};
      if (t >= {1'b0, d}) begin
        t     = t - {1'b0, d};
        s.num = {s.num[SUM_W-2:0], 1'b1};
      end else begin
        s.num = {s.num[SUM_W-2:0], 1'b0};
      end
      s.rem = t[SPP_W-1:0];
    end
    return s;
  endfunction

  // The fraction of the average is brought to Q0.16 before the root; anything
  // at or above 1.0 saturates the channel.
  function automatic root_lane_t root_init(logic [SUM_W-1:0] q);
    root_lane_t s;
    s.sat  = ((q >> COLOR_FRAC_BITS) != '0);
    s.rad  = RAD_W'((q >> SHR) << SHL);
    s.root = '0;
    s.rem  = '0;
    return s;
  endfunction

  // Digit-by-digit square root, two radicand bits per result bit.
  function automatic root_lane_t root_steps(root_lane_t a);
    root_lane_t       s;
    logic [REM_W-1:0] acc;
    logic [REM_W-1:0] trial;
    s = a;
    for (int i = 0; i < ROOT_BITS_PER_ST; i++) begin
      acc   = {s.rem[CHAN_W:0], s.rad[RAD_W-1 -: 2]};
      trial = {1'b0, s.root, 2'b01};
      s.rad = {s.rad[RAD_W-3:0], 2'b00};
      if (acc >= trial) begin
        s.rem  = acc - trial;
        s.root = {s.root[CHAN_W-2:0], 1'b1};
      end else begin
        s.rem  = acc;
        s.root = {s.root[CHAN_W-2:0], 1'b0};
      end
    end
    return s;
  endfunction

  div_lane_t  div_r  [DIV_STAGES][NUM_CHAN];
  meta_t      div_meta_r [DIV_STAGES];
  logic [DIV_STAGES-1:0] div_v_r;

  root_lane_t root_r [ROOT_STAGES][NUM_CHAN];
  meta_t      root_meta_r [ROOT_STAGES];
  logic [ROOT_STAGES-1:0] root_v_r;

  logic              out_v_r;
  logic              out_in_frame_r;
  logic [ADDR_W-1:0] out_addr_r;
  logic [WORD_W-1:0] out_word_r;

  logic              adv;
  meta_t             meta_in;
  logic [PROD_W-1:0] addr_full;
  logic [NUM_CHAN-1:0][CHAN_W-1:0] chan;

  // The whole pipeline moves when the output register is free or being taken.
  assign adv   = ~out_v_r | ~out_stall;
  assign q_pop = adv & ~q_empty;

  assign out_valid         = out_v_r;
  assign out_in_frame      = out_in_frame_r;
  assign out_pixel_address = out_addr_r;
  assign out_pixel_word    = out_word_r;

  always_comb begin
    addr_full = PROD_W'(q_data.row[DIM_W-1:0] * frame_w) + PROD_W'(q_data.col[DIM_W-1:0]);
    meta_in.in_frame = q_data.in_frame;
    meta_in.addr     = q_data.in_frame ? ADDR_W'(addr_full) : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      div_v_r  <= '0;
      root_v_r <= '0;
      out_v_r  <= 1'b0;
    end else if (adv) begin
      div_v_r  <= {div_v_r[DIV_STAGES-2:0], ~q_empty};
      root_v_r <= {root_v_r[ROOT_STAGES-2:0], div_v_r[DIV_STAGES-1]};
      out_v_r  <= root_v_r[ROOT_STAGES-1];
    end
  end

  for (genvar s = 0; s < DIV_STAGES; s++) begin : g_div
    if (s == 0) begin : g_first
      always_ff @(posedge clk) begin
        if (adv) begin
          div_meta_r[s] <= meta_in;
          for (int c = 0; c < NUM_CHAN; c++) begin
            div_r[s][c] <= div_steps('{rem: '0, num: q_data.sum[c]}, spp);
          end
        end
      end
    end else begin : g_next
      always_ff @(posedge clk) begin
        if (adv) begin
          div_meta_r[s] <= div_meta_r[s-1];
          for (int c = 0; c < NUM_CHAN; c++) begin
            div_r[s][c] <= div_steps(div_r[s-1][c], spp);
          end
        end
      end
    end
  end

  for (genvar s = 0; s < ROOT_STAGES; s++) begin : g_root
    if (s == 0) begin : g_first
      always_ff @(posedge clk) begin
        if (adv) begin
          root_meta_r[s] <= div_meta_r[DIV_STAGES-1];
          for (int c = 0; c < NUM_CHAN; c++) begin
            root_r[s][c] <= root_steps(root_init(div_r[DIV_STAGES-1][c].num));
          end
        end
      end
    end else begin : g_next
      always_ff @(posedge clk) begin
        if (adv) begin
          root_meta_r[s] <= root_meta_r[s-1];
          for (int c = 0; c < NUM_CHAN; c++) begin
            root_r[s][c] <= root_steps(root_r[s-1][c]);
          end
        end
      end
    end
  end

  always_comb begin
    for (int c = 0; c < NUM_CHAN; c++) begin
      chan[c] = root_r[ROOT_STAGES-1][c].sat ? CHAN_MAX : root_r[ROOT_STAGES-1][c].root;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_in_frame_r <= root_meta_r[ROOT_STAGES-1].in_frame;
      out_addr_r     <= root_meta_r[ROOT_STAGES-1].addr;
      out_word_r     <= {ALPHA_OPAQUE, chan[CH_RED], chan[CH_GREEN], chan[CH_BLUE]};
    end
  end

endmodule

// File: test/tb.sv
// Testbench for pixel_resolve_gamma_pack: table and random items checked against a predictor.
`timescale 1ns / 100ps

module tb;
  import prgp_pkg::*;

  typedef struct {
    logic signed [POS_W-1:0] pos_x;
    logic signed [POS_W-1:0] pos_y;
    logic [SUM_W-1:0]        red;
    logic [SUM_W-1:0]        green;
    logic [SUM_W-1:0]        blue;
  } pixel_in_t;

  typedef struct {
    logic              in_frame;
    logic [ADDR_W-1:0] addr;
    logic [WORD_W-1:0] word;
  } pixel_out_t;

  typedef struct {
    pixel_in_t  stim;
    bit         typed;
    pixel_out_t want;
  } table_row_t;

  localparam int ITEMS_PER_PHASE = 190;
  localparam int NUM_PHASES      = 6;
  localparam int LONG_HOLD       = 100;
  localparam int DRAIN_CYCLES    = 40;

  logic                    clk = 1'b0;
  logic                    rst_n = 1'b0;
  logic                    cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]    cfg_index = CFG_SPP;
  logic [CFG_DATA_W-1:0]   cfg_data = '0;
  logic                    in_valid = 1'b0;
  logic                    in_stall;
  logic signed [POS_W-1:0] in_pos_x = '0;
  logic signed [POS_W-1:0] in_pos_y = '0;
  logic [SUM_W-1:0]        in_red_sum = '0;
  logic [SUM_W-1:0]        in_green_sum = '0;
  logic [SUM_W-1:0]        in_blue_sum = '0;
  logic                    out_valid;
  logic                    out_stall = 1'b0;
  logic                    out_in_frame;
  logic [ADDR_W-1:0]       out_pixel_address;
  logic [WORD_W-1:0]       out_pixel_word;

  // Copy of the configuration as the block should hold it.
  logic [SPP_W-1:0]     spp_reg = SPP_RESET;
  logic [DIM_CFG_W-1:0] width_reg = WIDTH_RESET;
  logic [DIM_CFG_W-1:0] height_reg = HEIGHT_RESET;

  pixel_out_t pending_pixels[$];
  int         mismatch_count = 0;
  int         send_idle_pct = 0;
  int         recv_idle_pct = 0;
  int         hold_requests = 0;

  // Expected results at the reset configuration: 640 x 480, one sample.
  table_row_t pixel_table [12] = '{
    '{'{16'sd0, 16'sd479, 32'h0, 32'h0, 32'h0}, 1'b1, '{1'b1, 24'd0, 32'hFF000000}},
    '{'{16'sd639, 16'sd0, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF}, 1'b1,
      '{1'b1, 24'd307199, 32'hFFFFFFFF}},
    '{'{16'sd640, 16'sd0, 32'h4000, 32'h100, 32'h1}, 1'b1, '{1'b0, 24'd0, 32'hFF801001}},
    '{'{16'sd0, 16'sd480, 32'h10000, 32'h10000, 32'h10000}, 1'b1,
      '{1'b0, 24'd0, 32'hFFFFFFFF}},
    '{'{-16'sd1, 16'sd100, 32'hFFFF, 32'hFFFF, 32'hFFFF}, 1'b1,
      '{1'b0, 24'd0, 32'hFFFFFFFF}},
    '{'{-16'sd32768, -16'sd32768, 32'h0, 32'h0, 32'h0}, 1'b1,
      '{1'b0, 24'd0, 32'hFF000000}},
    '{'{16'sd32767, 16'sd32767, 32'h0, 32'h0, 32'h0}, 1'b1, '{1'b0, 24'd0, 32'hFF000000}},
    '{'{16'sd5, -16'sd1, 32'h0, 32'h0, 32'h0}, 1'b1, '{1'b0, 24'd0, 32'hFF000000}},
    '{'{16'sd1, 16'sd478, 32'h4000, 32'h0, 32'h0}, 1'b1, '{1'b1, 24'd641, 32'hFF800000}},
    '{'{16'sh5555, 16'shAAAA, 32'hAAAAAAAA, 32'h55555555, 32'h12345678}, 1'b0,
      '{1'b0, 24'd0, 32'h0}},
    '{'{16'sd320, 16'sd240, 32'h00009A3C, 32'h00C0FFEE, 32'h00000F0F}, 1'b0,
      '{1'b0, 24'd0, 32'h0}},
    '{'{16'sd17, 16'sd3, 32'h00002710, 32'h00000004, 32'h0000FFFE}, 1'b0,
      '{1'b0, 24'd0, 32'h0}}
  };

  pixel_resolve_gamma_pack dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_pos_x          (in_pos_x),
    .in_pos_y          (in_pos_y),
    .in_red_sum        (in_red_sum),
    .in_green_sum      (in_green_sum),
    .in_blue_sum       (in_blue_sum),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_in_frame      (out_in_frame),
    .out_pixel_address (out_pixel_address),
    .out_pixel_word    (out_pixel_word)
  );

  initial begin
    forever begin
      #5 clk = ~clk;
    end
  end

  initial begin
    #5_000_000;
    $display("TB_ERROR");
    $finish;
  end

  function automatic int eff_spp();
    return (spp_reg == '0) ? 1 : int'(spp_reg);
  endfunction

  function automatic int eff_dim(logic [DIM_CFG_W-1:0] dim);
    return (int'(dim) > MAX_DIM_DEF) ? MAX_DIM_DEF : int'(dim);
  endfunction

  function automatic logic [15:0] floor_sqrt(logic [31:0] v);
    logic [15:0] root;
    logic [15:0] cand;
    root = '0;
    for (int b = 15; b >= 0; b--) begin
      cand = root | (16'd1 << b);
      if ({32'd0, cand} * {32'd0, cand} <= {32'd0, v}) begin
        root = cand;
      end
    end
    return root;
  endfunction

  // Average, then gamma 2 as a square root, saturated to a byte.
  function automatic logic [CHAN_W-1:0] gamma_channel(logic [SUM_W-1:0] sum);
    logic [31:0] avg;
    logic [15:0] root;
    avg  = sum / eff_spp();
    root = floor_sqrt(avg);
    return (root > 16'd255) ? CHAN_MAX : root[7:0];
  endfunction

  function automatic pixel_out_t predict_pixel(pixel_in_t p);
    pixel_out_t r;
    int x;
    int y;
    int w;
    int h;
    int fy;
    x  = p.pos_x;
    y  = p.pos_y;
    w  = eff_dim(width_reg);
    h  = eff_dim(height_reg);
    fy = h - 1 - y;
    r.in_frame = (fy >= 0) && (fy < h) && (x >= 0) && (x < w);
    r.addr     = r.in_frame ? ADDR_W'(fy * w + x) : '0;
    r.word     = {ALPHA_OPAQUE, gamma_channel(p.red), gamma_channel(p.green),
                  gamma_channel(p.blue)};
    return r;
  endfunction

  function automatic logic [POS_W-1:0] pick_coord(int span);
    if ($urandom_range(0, 99) < 70) begin
      return POS_W'(int'($urandom_range(0, span + 3)) - 2);
    end
    return POS_W'($urandom);
  endfunction

  // Mostly sums whose average stays below 1.0, so the root is not saturated.
  function automatic logic [SUM_W-1:0] pick_sum();
    logic [31:0] full_scale;
    int sel;
    full_scale = 32'(eff_spp()) << 16;
    sel = $urandom_range(0, 99);
    if (sel < 40) begin
      return $urandom_range(0, full_scale - 1);
    end else if (sel < 55) begin
      return full_scale - 32'd8 + $urandom_range(0, 16);
    end else if (sel < 65) begin
      return $urandom_range(0, 1023);
    end
    return $urandom;
  endfunction

  task automatic note_failure(string what);
    if (mismatch_count < 10) begin
      $display("mismatch at %0t: %s", $time, what);
    end
    mismatch_count++;
  endtask

  // Called at a falling edge; returns at the falling edge after the item is taken.
  task automatic send_pixel(pixel_in_t p, bit typed, pixel_out_t want);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid     <= 1'b1;
    in_pos_x     <= p.pos_x;
    in_pos_y     <= p.pos_y;
    in_red_sum   <= p.red;
    in_green_sum <= p.green;
    in_blue_sum  <= p.blue;
    do begin
      @(posedge clk);
    end while (in_stall);
    pending_pixels.push_back(typed ? want : predict_pixel(p));
    @(negedge clk);
  endtask

  task automatic wait_drained();
    while (pending_pixels.size() != 0) begin
      @(negedge clk);
    end
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_config(logic [CFG_DATA_W-1:0] spp, logic [CFG_DATA_W-1:0] w,
                              logic [CFG_DATA_W-1:0] h);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_SPP;
    cfg_data  <= spp;
    @(negedge clk);
    cfg_index <= CFG_WIDTH;
    cfg_data  <= w;
    @(negedge clk);
    cfg_index <= CFG_HEIGHT;
    cfg_data  <= h;
    @(negedge clk);
    cfg_we     <= 1'b0;
    spp_reg    = spp[SPP_W-1:0];
    width_reg  = w;
    height_reg = h;
  endtask

  always @(posedge clk) begin
    pixel_out_t exp_px;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_pixels.size() == 0) begin
        note_failure($sformatf("unexpected result frame=%0b addr=%h word=%h",
                               out_in_frame, out_pixel_address, out_pixel_word));
      end else begin
        exp_px = pending_pixels.pop_front();
        if (out_in_frame !== exp_px.in_frame || out_pixel_address !== exp_px.addr ||
            out_pixel_word !== exp_px.word) begin
          note_failure($sformatf("expected frame=%0b addr=%h word=%h, got %0b %h %h",
                                 exp_px.in_frame, exp_px.addr, exp_px.word,
                                 out_in_frame, out_pixel_address, out_pixel_word));
        end
      end
    end
  end

  // Result side: random stalls, plus one long hold-off when asked for.
  initial begin
    int hold_left;
    int holds_done;
    hold_left  = 0;
    holds_done = 0;
    forever begin
      @(negedge clk);
      if (holds_done != hold_requests) begin
        holds_done = hold_requests;
        hold_left  = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
      end
    end
  end

  initial begin
    pixel_in_t  p;
    pixel_out_t none;
    none = '{1'b0, '0, '0};
    send_idle_pct = 11;
    recv_idle_pct = 54;
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (pixel_table[i]) begin
      send_pixel(pixel_table[i].stim, pixel_table[i].typed, pixel_table[i].want);
    end
    in_valid <= 1'b0;

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      wait_drained();
      case (ph)
        0: begin
          // Zero sample count and a frame larger than the maximum.
          write_config(13'd0, 13'h1FFF, 13'h1FFF);
        end
        1: begin
          // Upper bits of the sample count are dropped; no pixel is in frame.
          write_config(13'h1FFF, 13'd0, 13'd0);
        end
        2: begin
          write_config(13'd1024, 13'd4096, 13'd4096);
        end
        3: begin
          write_config(13'd1, 13'd1, 13'd1);
        end
        4: begin
          write_config(CFG_DATA_W'($urandom), CFG_DATA_W'($urandom_range(1, 300)),
                       CFG_DATA_W'($urandom_range(1, 300)));
        end
        default: begin
          write_config(CFG_DATA_W'($urandom_range(1, 40)), CFG_DATA_W'($urandom_range(1, 64)),
                       CFG_DATA_W'($urandom_range(1, 64)));
        end
      endcase
      if (ph < 2) begin
        send_idle_pct = 11;
        recv_idle_pct = 54;
      end else if (ph < 4) begin
        send_idle_pct = 54;
        recv_idle_pct = 11;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      if (ph == 2) begin
        hold_requests++;
      end
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        p.pos_x = pick_coord(eff_dim(width_reg));
        p.pos_y = pick_coord(eff_dim(height_reg));
        p.red   = pick_sum();
        p.green = pick_sum();
        p.blue  = pick_sum();
        send_pixel(p, 1'b0, none);
      end
      in_valid <= 1'b0;
    end

    wait_drained();
    if (mismatch_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
